>>> rtl/core/no_triple_run_count_mod_prime_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the run-free sequence counter
// Shared concurrent-check forms, clocked on i_clk and masked during reset.
// ----------------------------------------------------------------------------
`ifndef NO_TRIPLE_RUN_COUNT_MOD_PRIME_MACROS_SVH
`define NO_TRIPLE_RUN_COUNT_MOD_PRIME_MACROS_SVH

// Same-cycle implication
`define NTR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define NTR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/ntr_pkg.sv
// ----------------------------------------------------------------------------
// ntr_pkg
// Prime modulus, Montgomery constants and small modular helpers.
// ----------------------------------------------------------------------------
package ntr_pkg;

    localparam logic [29:0] P_MOD = 30'd1000000007;

    // -P^-1 mod 2^32 by Newton iteration
    function automatic logic [31:0] f_neg_inv();
        logic [31:0] p32;
        logic [31:0] inv;
        p32 = {2'b00, P_MOD};
        inv = p32;
        for (int i = 0; i < 5; i++) begin
            inv = inv * (32'd2 - p32 * inv);
        end
        return 32'd0 - inv;
    endfunction

    // 2^k mod P by repeated doubling
    function automatic logic [29:0] f_pow2_mod(input int k);
        logic [30:0] r;
        r = 31'd1;
        for (int i = 0; i < k; i++) begin
            r = {r[29:0], 1'b0};
            if (r >= {1'b0, P_MOD}) begin
                r = r - {1'b0, P_MOD};
            end
        end
        return r[29:0];
    endfunction

    localparam logic [31:0] P_NEG_INV = f_neg_inv();
    localparam logic [29:0] R1_MOD    = f_pow2_mod(32);
    localparam logic [29:0] R2_MOD    = f_pow2_mod(64);
    // Montgomery factor that scales a slice by 2^30
    localparam logic [29:0] MID_MONT  = f_pow2_mod(62);

    function automatic logic [29:0] f_addmod(input logic [29:0] a, input logic [29:0] b);
        logic [30:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, P_MOD}) begin
            s = s - {1'b0, P_MOD};
        end
        return s[29:0];
    endfunction

    // h * 2^60 mod P for h in 0..15, 30 bits per entry
    function automatic logic [479:0] f_hi_table();
        logic [479:0] t;
        logic [29:0]  step;
        logic [29:0]  v;
        t    = '0;
        step = f_pow2_mod(60);
        v    = 30'd0;
        for (int h = 0; h < 16; h++) begin
            t[h*30 +: 30] = v;
            v = f_addmod(v, step);
        end
        return t;
    endfunction

    localparam logic [479:0] HI_TAB = f_hi_table();

endpackage

>>> rtl/core/ntr_modred.sv
// ----------------------------------------------------------------------------
// ntr_modred
// Folds the low 30 bits and the top 4 bits of a 64-bit value mod P into a
// registered result; the middle 30 bits go through the shared multiplier.
// ----------------------------------------------------------------------------
module ntr_modred
    import ntr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_go,
    input  logic [63:0] i_val,
    output logic [29:0] o_res
);

    logic [29:0] r_lo;
    logic [29:0] w_low;
    logic [8:0]  w_sel;
    logic [29:0] w_top;

    assign w_low = (i_val[29:0] >= P_MOD) ? i_val[29:0] - P_MOD : i_val[29:0];
    assign w_sel = 9'(i_val[63:60]) * 9'd30;
    assign w_top = HI_TAB[w_sel +: 30];

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_lo <= f_addmod(w_low, w_top);
        end
    end

    assign o_res = r_lo;

endmodule

>>> rtl/core/ntr_mulmod.sv
// ----------------------------------------------------------------------------
// ntr_mulmod
// Montgomery multiply mod P (R = 2^32) on one shared 32x32 multiplier.
// ----------------------------------------------------------------------------
module ntr_mulmod
    import ntr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_go,
    input  logic [29:0] i_a,
    input  logic [29:0] i_b,
    output logic        o_done,
    output logic [29:0] o_res
);

    typedef enum logic [4:0] {
        M_IDLE = 5'b00001,
        M_PROD = 5'b00010,
        M_QUOT = 5'b00100,
        M_FOLD = 5'b01000,
        M_SUB  = 5'b10000
    } t_mstate;

    t_mstate     r_state, n_state;
    logic [31:0] r_a, r_b;
    logic [59:0] r_t;
    logic [31:0] r_q;
    logic [30:0] r_s;
    logic [29:0] r_res;
    logic        r_done;
    logic [31:0] w_mx, w_my;
    logic [63:0] w_prod;
    logic [62:0] w_sum;

    // single shared multiplier, operands selected by step
    always_comb begin
        case (r_state)
            M_PROD: begin
                w_mx = r_a;
                w_my = r_b;
            end
            M_QUOT: begin
                w_mx = r_t[31:0];
                w_my = P_NEG_INV;
            end
            default: begin
                w_mx = r_q;
                w_my = {2'b00, P_MOD};
            end
        endcase
    end

    assign w_prod = w_mx * w_my;
    assign w_sum  = {3'b000, r_t} + w_prod[62:0];

    always_comb begin
        case (r_state)
            M_IDLE:  n_state = i_go ? M_PROD : M_IDLE;
            M_PROD:  n_state = M_QUOT;
            M_QUOT:  n_state = M_FOLD;
            M_FOLD:  n_state = M_SUB;
            M_SUB:   n_state = M_IDLE;
            default: n_state = M_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == M_SUB);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == M_IDLE && i_go) begin
            r_a <= {2'b00, i_a};
            r_b <= {2'b00, i_b};
        end
        if (r_state == M_PROD) begin
            r_t <= w_prod[59:0];
        end
        if (r_state == M_QUOT) begin
            r_q <= w_prod[31:0];
        end
        if (r_state == M_FOLD) begin
            r_s <= w_sum[62:32];
        end
        if (r_state == M_SUB) begin
            r_res <= (r_s >= {1'b0, P_MOD}) ? 30'(r_s - {1'b0, P_MOD}) : r_s[29:0];
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

>>> rtl/core/no_triple_run_count_mod_prime.sv
// ----------------------------------------------------------------------------
// no_triple_run_count_mod_prime
// Counts length-n sequences over m symbols with no run of three, mod P.
// ----------------------------------------------------------------------------
// Usage:
//   Present i_length_n and i_symbols_m with start high while busy is low; the
//   transaction is taken at that edge and busy rises. When the count is ready,
//   o_done pulses for one cycle with o_count_mod valid; busy is already low in
//   that cycle, so the next command may be taken at the edge that ends it.
//   The receiver cannot stall: the result must be captured in its strobe cycle.
// Operation:
//   Every product runs through one Montgomery multiply on the shared 32x32
//   multiplier. The middle 30 bits of m take one product; the low slice is
//   folded in by a subtraction, the top slice through a small constant table.
//   Length zero or one: o_done follows the reduction of m alone.
//   Otherwise one product converts m-1, each bit of n-1 costs a squaring of
//   the base plus a product into the accumulator when the bit is set, and a
//   last product scales by m. A new transaction is taken only once the last
//   one has returned its result.
// Reset:
//   Synchronous active-low reset returns to idle and drops any pending work.
// ----------------------------------------------------------------------------
`include "no_triple_run_count_mod_prime_macros.svh"

module no_triple_run_count_mod_prime
    import ntr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] i_length_n,
    input  logic [63:0] i_symbols_m,
    output logic        o_done,
    output logic [29:0] o_count_mod
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_RED  = 6'b000010,
        S_CONV = 6'b000100,
        S_CHK  = 6'b001000,
        S_MUL  = 6'b010000,
        S_FIN  = 6'b100000
    } t_state;

    t_state      r_state, n_state;
    logic [63:0] r_n, n_n;
    logic [63:0] r_e, n_e;
    logic [29:0] r_m, n_m;
    logic [29:0] r_acc  [4];
    logic [29:0] n_acc  [4];
    logic [29:0] r_base [4];
    logic [29:0] n_base [4];
    logic [29:0] r_tmp  [4];
    logic [29:0] n_tmp  [4];
    logic [29:0] r_part, n_part;
    logic [2:0]  r_k, n_k;
    logic        r_sq, n_sq;
    logic        r_go, n_go;
    logic [29:0] r_opa, n_opa;
    logic [29:0] r_opb, n_opb;
    logic        r_done, n_done;
    logic [29:0] r_count, n_count;

    logic        w_red_go;
    logic [29:0] w_red_res;
    logic        w_mul_done;
    logic [29:0] w_mul_res;
    logic [29:0] w_msum;
    logic [29:0] w_mm1;

    assign w_red_go = start && (r_state == S_IDLE);
    assign w_msum   = f_addmod(w_red_res, w_mul_res);
    assign w_mm1    = (w_msum == 30'd0) ? P_MOD - 30'd1 : w_msum - 30'd1;

    ntr_modred u_modred (
        .i_clk   (i_clk),
        .i_go    (w_red_go),
        .i_val   (i_symbols_m),
        .o_res   (w_red_res)
    );

    ntr_mulmod u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (r_go),
        .i_a     (r_opa),
        .i_b     (r_opb),
        .o_done  (w_mul_done),
        .o_res   (w_mul_res)
    );

    always_comb begin
        n_state = r_state;
        n_n     = r_n;
        n_e     = r_e;
        n_m     = r_m;
        n_acc   = r_acc;
        n_base  = r_base;
        n_tmp   = r_tmp;
        n_part  = r_part;
        n_k     = r_k;
        n_sq    = r_sq;
        n_go    = 1'b0;
        n_opa   = r_opa;
        n_opb   = r_opb;
        n_done  = 1'b0;
        n_count = r_count;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_n     = i_length_n;
                    // middle slice of m times 2^30 through the multiplier
                    n_opa   = i_symbols_m[59:30];
                    n_opb   = MID_MONT;
                    n_go    = 1'b1;
                    n_state = S_RED;
                end
            end
            S_RED: begin
                if (w_mul_done) begin
                    n_m = w_msum;
                    if (r_n == 64'd0) begin
                        n_count = 30'd1;
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                    end else if (r_n == 64'd1) begin
                        n_count = w_msum;
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        // bring m-1 into Montgomery form
                        n_opa   = w_mm1;
                        n_opb   = R2_MOD;
                        n_go    = 1'b1;
                        n_state = S_CONV;
                    end
                end
            end
            S_CONV: begin
                if (w_mul_done) begin
                    n_base[0] = 30'd0;
                    n_base[1] = R1_MOD;
                    n_base[2] = w_mul_res;
                    n_base[3] = w_mul_res;
                    n_acc[0]  = R1_MOD;
                    n_acc[1]  = 30'd0;
                    n_acc[2]  = 30'd0;
                    n_acc[3]  = R1_MOD;
                    n_e       = r_n - 64'd1;
                    n_state   = S_CHK;
                end
            end
            S_CHK: begin
                if (r_e == 64'd0) begin
                    // plain m times Montgomery sum leaves the plain product
                    n_opa   = f_addmod(r_acc[1], r_acc[3]);
                    n_opb   = r_m;
                    n_go    = 1'b1;
                    n_state = S_FIN;
                end else begin
                    n_k     = 3'd0;
                    n_sq    = !r_e[0];
                    n_go    = 1'b1;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                if (w_mul_done) begin
                    if (!r_k[0]) begin
                        n_part = w_mul_res;
                    end else begin
                        n_tmp[r_k[2:1]] = f_addmod(r_part, w_mul_res);
                    end
                    if (r_k == 3'd7) begin
                        if (r_sq) begin
                            n_base  = n_tmp;
                            n_e     = {1'b0, r_e[63:1]};
                            n_state = S_CHK;
                        end else begin
                            // acc updated; square the base next
                            n_acc = n_tmp;
                            n_sq  = 1'b1;
                            n_k   = 3'd0;
                            n_go  = 1'b1;
                        end
                    end else begin
                        n_k  = r_k + 3'd1;
                        n_go = 1'b1;
                    end
                end
            end
            S_FIN: begin
                if (w_mul_done) begin
                    n_count = w_mul_res;
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // matrix product operands: x[i][t] * base[t][j], k = {i, j, t}
        if (n_go && n_state == S_MUL) begin
            n_opa = n_sq ? r_base[{n_k[2], n_k[0]}] : r_acc[{n_k[2], n_k[0]}];
            n_opb = r_base[{n_k[0], n_k[1]}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_go    <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_go    <= n_go;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n     <= n_n;
        r_e     <= n_e;
        r_m     <= n_m;
        r_acc   <= n_acc;
        r_base  <= n_base;
        r_tmp   <= n_tmp;
        r_part  <= n_part;
        r_k     <= n_k;
        r_sq    <= n_sq;
        r_opa   <= n_opa;
        r_opb   <= n_opb;
        r_count <= n_count;
    end

    assign busy        = (r_state != S_IDLE);
    assign o_done      = r_done;
    assign o_count_mod = r_count;

    `NTR_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted transaction did not raise busy")
    `NTR_ASSERT_IMP(a_done_idle, o_done, !busy, "result strobe while busy")
    `NTR_ASSERT_IMP(a_count_range, o_done, o_count_mod < P_MOD, "result not reduced mod P")
    `NTR_ASSERT_IMP(a_go_in_work, r_go, busy, "multiply started while idle")

endmodule

>>> tb/sv/no_triple_run_count_mod_prime_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Run-free sequence count checker
// Watches the command and result channels, computes the expected count for
// every accepted transaction and compares it with each result strobe.
// ----------------------------------------------------------------------------
module no_triple_run_count_mod_prime_checker
    import ntr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [63:0] i_length_n,
    input  logic [63:0] i_symbols_m,
    input  logic        o_done,
    input  logic [29:0] o_count_mod,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_result_count
);

    typedef struct {
        logic [63:0] q00, q01, q10, q11;
    } mat_t;

    logic [29:0] count_queue[$];

    function automatic logic [63:0] mul_p(input logic [63:0] a, input logic [63:0] b);
        return (a * b) % 64'd1000000007;
    endfunction

    function automatic mat_t mat_mul(input mat_t a, input mat_t b);
        mat_t r;
        r.q00 = (mul_p(a.q00, b.q00) + mul_p(a.q01, b.q10)) % 64'd1000000007;
        r.q01 = (mul_p(a.q00, b.q01) + mul_p(a.q01, b.q11)) % 64'd1000000007;
        r.q10 = (mul_p(a.q10, b.q00) + mul_p(a.q11, b.q10)) % 64'd1000000007;
        r.q11 = (mul_p(a.q10, b.q01) + mul_p(a.q11, b.q11)) % 64'd1000000007;
        return r;
    endfunction

    function automatic logic [29:0] run_free_count(input logic [63:0] len,
                                                   input logic [63:0] syms);
        logic [63:0] m;
        logic [63:0] mm1;
        logic [63:0] e;
        mat_t base;
        mat_t acc;
        m = syms % 64'd1000000007;
        if (len == 64'd0) return 30'd1;
        if (len == 64'd1) return m[29:0];
        mm1 = (m + 64'd1000000006) % 64'd1000000007;
        base = '{64'd0, 64'd1, mm1, mm1};
        acc = '{64'd1, 64'd0, 64'd0, 64'd1};
        e = len - 64'd1;
        while (e != 64'd0) begin
            if (e[0]) acc = mat_mul(acc, base);
            base = mat_mul(base, base);
            e = e >> 1;
        end
        e = mul_p((acc.q01 + acc.q11) % 64'd1000000007, m);
        return e[29:0];
    endfunction

    assign o_pending = count_queue.size();

    always @(posedge i_clk) begin
        logic [29:0] want;
        if (i_rst_n) begin
            if (start && !busy) count_queue.push_back(run_free_count(i_length_n, i_symbols_m));
            if (o_done) begin
                o_result_count++;
                if (count_queue.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("mismatch: unexpected result count_mod=%0d", o_count_mod);
                end else begin
                    want = count_queue.pop_front();
                    if (want !== o_count_mod) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("mismatch: count_mod expected %0d got %0d",
                                     want, o_count_mod);
                    end
                end
            end
        end
    end

endmodule

>>> tb/sv/no_triple_run_count_mod_prime_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Run-free sequence counter testbench
// Drives directed and random length/alphabet commands with bursty gaps and
// relies on the checker for a predicted count per transaction.
// ----------------------------------------------------------------------------
module no_triple_run_count_mod_prime_tb;

    localparam logic [63:0] PRIME   = 64'd1000000007;
    localparam logic [63:0] ALL_ONE = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam int          STALL_LIMIT = 40000;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [63:0] i_length_n;
    logic [63:0] i_symbols_m;
    logic        o_done;
    logic [29:0] o_count_mod;
    int          fail_count;
    int          pending;
    int          result_count;
    int          sent_count;
    int          idle_cycles;
    logic        timed_out = 1'b0;

    no_triple_run_count_mod_prime dut (.*);

    no_triple_run_count_mod_prime_checker u_checker (
        .i_clk, .i_rst_n, .start, .busy, .i_length_n, .i_symbols_m,
        .o_done, .o_count_mod,
        .o_fail_count(fail_count), .o_pending(pending), .o_result_count(result_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Watchdog: count cycles with no transaction in either direction
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
    end

    always @(posedge i_clk) begin
        if (idle_cycles >= STALL_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("watchdog expired");
            $display("** no_triple_run_count_mod_prime: FAILED **");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Present one command and hold until the block takes it
    task automatic send_cmd(input logic [63:0] len, input logic [63:0] syms);
        i_length_n  = len;
        i_symbols_m = syms;
        start       = 1'b1;
        do @(posedge i_clk); while (busy);
        sent_count++;
        @(negedge i_clk);
        start = 1'b0;
    endtask

    task automatic idle_gap(input int cycles);
        repeat (cycles) @(negedge i_clk);
    endtask

    task automatic send_random();
        logic [63:0] len;
        logic [63:0] syms;
        int sel;
        sel = $urandom_range(0, 9);
        // Mostly short lengths; a few full 64-bit ones
        case (sel)
            0: len = rand64();
            1, 2: len = 64'd1 + $urandom_range(0, 3);
            default: len = 64'd1 + (rand64() >> $urandom_range(40, 63));
        endcase
        if (len == 64'd0) len = 64'd1;
        sel = $urandom_range(0, 5);
        case (sel)
            0: syms = PRIME * $urandom_range(0, 1000);
            1: syms = $urandom_range(0, 10);
            2: syms = PRIME * $urandom_range(1, 5) + $urandom_range(0, 2) - 64'd1;
            default: syms = rand64();
        endcase
        send_cmd(len, syms);
    endtask

    initial begin
        sent_count  = 0;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_length_n  = 64'd1;
        i_symbols_m = 64'd0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_cmd(64'd1, 64'd0);
        send_cmd(64'd1, ALL_ONE);
        send_cmd(64'd1, PRIME);
        send_cmd(64'd1, PRIME - 64'd1);
        send_cmd(64'd2, 64'd1);
        send_cmd(64'd2, 64'd2);
        send_cmd(64'd3, 64'd2);
        send_cmd(64'd3, 64'd1);
        send_cmd(64'd4, 64'd3);
        send_cmd(64'd5, 64'd0);
        send_cmd(64'd7, PRIME);
        send_cmd(64'd9, PRIME * 64'd3);
        send_cmd(64'd10, PRIME + 64'd1);
        send_cmd(ALL_ONE, ALL_ONE);
        send_cmd(ALL_ONE, 64'd2);
        send_cmd(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000);
        send_cmd(64'h8000_0000_0000_0001, 64'd5);
        send_cmd(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
        send_cmd(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
        send_cmd(64'd1000, 64'd26);

        // Hold until every outstanding count has returned
        while (pending != 0) @(negedge i_clk);

        for (int k = 0; k < 560; k++) begin
            if ($urandom_range(0, 3) == 0) idle_gap($urandom_range(0, 30));
            if (k == 280) while (pending != 0) @(negedge i_clk);
            send_random();
        end

        while (pending != 0) @(negedge i_clk);
        idle_gap(200);

        $display("sent %0d commands, checked %0d counts (short, full-width and multiple-of-P)",
                 sent_count, result_count);
        if (fail_count == 0 && pending == 0) begin
            $display("** no_triple_run_count_mod_prime: PASSED **");
        end else begin
            $display("** no_triple_run_count_mod_prime: FAILED **");
        end
        $finish;
    end

endmodule
